[design/swpb_pkg.sv]
// Shared types and constants for the servo write packet builder.
`default_nettype none

package swpb_pkg;

	typedef logic [7:0] byte_t;

	// Longest packet: two sync bytes, ten body bytes and the checksum.
	localparam int unsigned PktBytes  = 13;
	localparam int unsigned BodyBytes = 10;
	localparam int unsigned CntBits   = $clog2(PktBytes + 1);

	typedef logic [PktBytes-1:0][7:0]  pkt_t;
	typedef logic [BodyBytes:0][7:0]   body_t;
	typedef logic [CntBits-1:0]        cnt_t;

	typedef enum logic [1:0] {
		KIND_TORQUE   = 2'd0,
		KIND_POSITION = 2'd1,
		KIND_SPEED    = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_TORQUE_ADDR   = 2'd0,
		REG_POSITION_ADDR = 2'd1,
		REG_SPEED_ADDR    = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	localparam byte_t SYNC_BYTE    = 8'hFF;
	localparam byte_t OP_WRITE     = 8'h03;
	localparam byte_t LEN_TORQUE   = 8'd4;
	localparam byte_t LEN_POSITION = 8'd9;
	localparam byte_t LEN_SPEED    = 8'd5;

	localparam byte_t TORQUE_ADDR_RST   = 8'd40;
	localparam byte_t POSITION_ADDR_RST = 8'd42;
	localparam byte_t SPEED_ADDR_RST    = 8'd46;

	localparam logic [15:0] DIR_BIT   = 16'h8000;
	localparam logic [15:0] SPEED_MIN = 16'h8000;
	localparam logic [15:0] MAG_MAX   = 16'h7FFF;

endpackage

`default_nettype wire

[design/servo_write_packet_builder.sv]
// Top level of the servo write packet builder: command in, packet bytes out.
//
// A command word (kind, servo_id, enable_value, goal_position, speed) is taken on
// the input valid/ready channel. The block answers with the whole write packet on
// the output valid/ready channel, one byte per word: FF FF, id, length, 03,
// register address, data, checksum. last_byte marks the checksum word.
// Torque enable packets are 8 words, motor speed packets 9, goal position 13.
// Kind 3 produces no words and is dropped when it leaves the input register.
// With the output idle, an accepted command passes through the input register
// and is then loaded into the output shift register, which offers its first byte.
// Bytes leave at one per cycle while out_ready is high, all from the single
// output shift register.
// One command waits in the input register while a packet drains, so the next
// packet follows the previous checksum byte without a gap.
// When the receiver holds out_ready low the current byte stays and the shift
// register does not move; in_ready stays low while the input register holds a command
// that cannot move on.
// Reset clears both valid flags and loads the default register addresses
// (torque 40, position 42, speed 46). The user must write them through the cfg port
// only while the block is idle; the block does not enforce this. An index of 3 is ignored.
`default_nettype none

module servo_write_packet_builder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   kind,
	input  wire logic [7:0]   servo_id,
	input  wire logic [7:0]   enable_value,
	input  wire logic [11:0]  goal_position,
	input  wire logic signed [15:0] speed,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        packet_byte,
	output logic              last_byte,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [7:0]   cfg_data
);

	swpb_pkg::byte_t torque_addr_q, position_addr_q, speed_addr_q;

	logic            valid_s1;
	swpb_pkg::kind_t kind_s1;
	logic [7:0]      id_s1;
	logic [7:0]      enable_s1;
	logic [11:0]     pos_s1;
	logic [15:0]     speed_s1;

	swpb_pkg::pkt_t  bytes_q;
	swpb_pkg::cnt_t  cnt_q;

	swpb_pkg::body_t body;
	swpb_pkg::cnt_t  body_len;
	swpb_pkg::byte_t chk_sum;
	swpb_pkg::pkt_t  pkt_d;
	swpb_pkg::cnt_t  pkt_len;
	logic [15:0]     motor_word;
	logic [15:0]     magnitude;
	logic            load;
	logic            out_fire;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_addr_q   <= swpb_pkg::TORQUE_ADDR_RST;
			position_addr_q <= swpb_pkg::POSITION_ADDR_RST;
			speed_addr_q    <= swpb_pkg::SPEED_ADDR_RST;
		end else if (cfg_we) begin
			unique case (swpb_pkg::reg_index_t'(cfg_index))
				swpb_pkg::REG_TORQUE_ADDR:   torque_addr_q   <= cfg_data;
				swpb_pkg::REG_POSITION_ADDR: position_addr_q <= cfg_data;
				swpb_pkg::REG_SPEED_ADDR:    speed_addr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_fire = out_valid && out_ready;
	// The held command moves on when the shift register is empty or its last
	// byte leaves in this cycle.
	assign load     = valid_s1 && ((cnt_q == '0) || (cnt_q == swpb_pkg::cnt_t'(1) && out_ready));
	assign in_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= swpb_pkg::kind_t'(kind);
			id_s1     <= servo_id;
			enable_s1 <= enable_value;
			pos_s1    <= goal_position;
			speed_s1  <= speed;
		end
	end

	// Sign-magnitude motor word; the most negative pattern saturates to 0xFFFF.
	always_comb begin
		magnitude = 16'(~speed_s1 + 16'd1);
		if (speed_s1 == swpb_pkg::SPEED_MIN) begin
			magnitude = swpb_pkg::MAG_MAX;
		end
		if ((speed_s1 & swpb_pkg::DIR_BIT) != 16'd0) begin
			motor_word = magnitude | swpb_pkg::DIR_BIT;
		end else begin
			motor_word = speed_s1;
		end
	end

	// Packet body from id onward; unused entries stay zero so the sum can
	// run over the first ten entries.
	always_comb begin
		body     = '0;
		body_len = '0;
		unique case (kind_s1)
			swpb_pkg::KIND_TORQUE: begin
				body[0]  = id_s1;
				body[1]  = swpb_pkg::LEN_TORQUE;
				body[2]  = swpb_pkg::OP_WRITE;
				body[3]  = torque_addr_q;
				body[4]  = enable_s1;
				body_len = swpb_pkg::cnt_t'(5);
			end
			swpb_pkg::KIND_POSITION: begin
				body[0]  = id_s1;
				body[1]  = swpb_pkg::LEN_POSITION;
				body[2]  = swpb_pkg::OP_WRITE;
				body[3]  = position_addr_q;
				body[4]  = pos_s1[7:0];
				body[5]  = {4'd0, pos_s1[11:8]};
				body[8]  = speed_s1[7:0];
				body[9]  = speed_s1[15:8];
				body_len = swpb_pkg::cnt_t'(10);
			end
			swpb_pkg::KIND_SPEED: begin
				body[0]  = id_s1;
				body[1]  = swpb_pkg::LEN_SPEED;
				body[2]  = swpb_pkg::OP_WRITE;
				body[3]  = speed_addr_q;
				body[4]  = motor_word[7:0];
				body[5]  = motor_word[15:8];
				body_len = swpb_pkg::cnt_t'(6);
			end
			swpb_pkg::KIND_NONE: begin
				body_len = '0;
			end
		endcase
	end

	always_comb begin
		chk_sum = '0;
		for (int i = 0; i < swpb_pkg::BodyBytes; i++) begin
			chk_sum = 8'(chk_sum + body[i]);
		end
	end

	// Sync bytes, body, then the inverted sum right after the last body byte.
	always_comb begin
		pkt_d    = '0;
		pkt_d[0] = swpb_pkg::SYNC_BYTE;
		pkt_d[1] = swpb_pkg::SYNC_BYTE;
		for (int j = 0; j <= swpb_pkg::BodyBytes; j++) begin
			pkt_d[j+2] = (swpb_pkg::cnt_t'(j) == body_len) ? ~chk_sum : body[j];
		end
		pkt_len = (kind_s1 == swpb_pkg::KIND_NONE) ? '0 :
			swpb_pkg::cnt_t'(body_len + swpb_pkg::cnt_t'(3));
	end

	// Output shift register: the byte on the port is always entry 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pkt_len;
		end else if (out_fire) begin
			cnt_q <= swpb_pkg::cnt_t'(cnt_q - swpb_pkg::cnt_t'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= pkt_d;
		end else if (out_fire) begin
			bytes_q <= {8'h00, bytes_q[swpb_pkg::PktBytes-1:1]};
		end
	end

	assign out_valid   = (cnt_q != '0);
	assign packet_byte = bytes_q[0];
	assign last_byte   = (cnt_q == swpb_pkg::cnt_t'(1));

endmodule

`default_nettype wire
